// ===== rtl/sli_pkg.sv =====
// Package for the sorted list store: sizes, codes and the cell link type.
`default_nettype none
package sli_pkg;

   // Number of entries the store can hold
   localparam int unsigned CAPACITY = 16;
   // Entry width and count width (count must hold CAPACITY itself)
   localparam int unsigned ENTRY_W  = 32;
   localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
   // Width of the entry count field on the response channel
   localparam int unsigned RSP_COUNT_W = 5;

   // Request command codes
   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } sli_cmd_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_MISSING = 2'd1,
      STATUS_FULL    = 2'd2
   } sli_status_type;

   // Compare results handed from one cell to the next one up the chain
   typedef struct packed {
      logic less;   // this cell holds a valid entry below the request value
      logic found;  // a valid entry equal to the value sits here or lower down
   } sli_link_type;

   // Per-request control broadcast to every cell
   typedef struct packed {
      logic do_insert;  // shift up and drop the value in its slot
      logic do_delete;  // close the gap over the first equal entry
   } sli_ctrl_type;

endpackage : sli_pkg
`default_nettype wire

// ===== rtl/sorted_list_insert_delete.sv =====
// Top level of the sorted list store: request decode, cell chain and response register.
`default_nettype none
// Sorted store of up to CAPACITY (16) signed 32-bit values kept in ascending order in a
// chain of cells. A request either inserts a value (ahead of any equal entries) or deletes
// the first entry equal to the key; each request gives exactly one response with a status
// (done, key not found, store full) and the entry count afterwards. Every cell compares
// its entry with the request value in the same cycle and shifts by one place, so a request
// is taken every cycle unless the response is held; it is answered in the cycle after
// acceptance. The cycle is set by the 32-bit compare in each cell and the ripple of the
// match flag. The response register frees the request side once its response is taken.
module sorted_list_insert_delete (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] value
   input  wire logic [0:0]  req_tuser,    // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [4:0] entry_count, [7:5] zero
   output logic [1:0]       rsp_tuser     // [1:0] status
);
   import sli_pkg::*;

   logic                      req_fire;
   logic signed [ENTRY_W-1:0] value;
   sli_cmd_type               cmd;
   logic                      full;
   logic                      found;
   sli_ctrl_type              ctrl;
   sli_status_type            status;

   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sli_status_type            rsp_status_ff;
   logic [RSP_COUNT_W-1:0]    rsp_count_ff;

   sli_link_type              link   [CAPACITY+1];
   logic signed [ENTRY_W-1:0] entries[CAPACITY];

   // Request decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign value      = $signed(req_tdata);
   assign cmd        = sli_cmd_type'(req_tuser[0]);
   assign full       = (count_ff == COUNT_W'(CAPACITY));
   assign found      = link[CAPACITY].found;

   assign ctrl.do_insert = req_fire && (cmd == CMD_INSERT) && !full;
   assign ctrl.do_delete = req_fire && (cmd == CMD_DELETE) && found;

   // The bottom of the chain counts as below the request value and sees no match
   assign link[0].less  = 1'b1;
   assign link[0].found = 1'b0;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ENTRY_W-1:0] entry_lo;
      logic signed [ENTRY_W-1:0] entry_hi;
      if (i == 0) begin : g_bottom
         assign entry_lo = value;
      end else begin : g_lower
         assign entry_lo = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign entry_hi = entries[i];
      end else begin : g_upper
         assign entry_hi = entries[i+1];
      end
      sli_cell u_cell (
         .clock    (clock),
         .valid    (count_ff > COUNT_W'(i)),
         .value    (value),
         .ctrl     (ctrl),
         .link_lo  (link[i]),
         .entry_lo (entry_lo),
         .entry_hi (entry_hi),
         .link_hi  (link[i+1]),
         .entry    (entries[i])
      );
   end

   // Status and new count
   always_comb begin
      status   = STATUS_DONE;
      count_in = count_ff;
      case (cmd)
         CMD_INSERT: begin
            if (full) status = STATUS_FULL;
            else      count_in = count_ff + 1'b1;
         end
         default: begin
            if (!found) status = STATUS_MISSING;
            else        count_in = count_ff - 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) count_ff <= count_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= RSP_COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && (cmd == CMD_INSERT) && full |=> rsp_tuser == STATUS_FULL)
      else $error("insert into full store not refused");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.do_insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.do_delete |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the count");

   a_missing_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (cmd == CMD_DELETE) && !found |=> $stable(count_ff))
      else $error("failed delete changed the count");

endmodule : sorted_list_insert_delete
`default_nettype wire

// ===== rtl/sli_cell.sv =====
// One slot of the sorted store: holds an entry, compares it and shifts.
`default_nettype none
module sli_cell (
   input  wire logic                                   clock,
   input  wire logic                                   valid,       // slot below count
   input  wire logic signed [sli_pkg::ENTRY_W-1:0]     value,       // request value
   input  wire sli_pkg::sli_ctrl_type                  ctrl,
   input  wire sli_pkg::sli_link_type                  link_lo,     // from the cell below
   input  wire logic signed [sli_pkg::ENTRY_W-1:0]     entry_lo,    // entry of the cell below
   input  wire logic signed [sli_pkg::ENTRY_W-1:0]     entry_hi,    // entry of the cell above
   output sli_pkg::sli_link_type                       link_hi,     // to the cell above
   output logic signed [sli_pkg::ENTRY_W-1:0]          entry
);
   import sli_pkg::*;

   logic signed [ENTRY_W-1:0] entry_ff;
   logic signed [ENTRY_W-1:0] entry_in;
   logic                      less;
   logic                      equal;

   // Local compare against the request value
   assign less  = valid && (entry_ff < value);
   assign equal = valid && (entry_ff == value);

   assign link_hi.less  = less;
   assign link_hi.found = link_lo.found | equal;
   assign entry         = entry_ff;

   // Next entry: keep, take the new value, take from below or from above
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert && !less) begin
         entry_in = link_lo.less ? value : entry_lo;
      end else if (ctrl.do_delete && link_hi.found) begin
         entry_in = entry_hi;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : sli_cell
`default_nettype wire
